// ===== hdl/nca_pkg.sv =====
package nca_pkg;

    // Defaults for the top-level parameters
    localparam int NUM_SLOTS_DEF  = 8;
    localparam int DIM_DEF        = 3;
    localparam int COORD_BITS_DEF = 16;

    // Fixed field widths of the channels
    localparam int SLOT_W  = 3;
    localparam int DIMI_W  = 2;
    localparam int COORD_W = 16;
    localparam int IDENT_W = 16;
    localparam int PIDX_W  = 32;
    localparam int CFG_W   = 4;

    // Distance accumulator, saturating at its all-ones value
    localparam int                ACC_W   = 36;
    localparam logic [ACC_W-1:0]  ACC_MAX = '1;

    // Candidate count after reset
    localparam logic [CFG_W-1:0] NUM_CAND_RST = 4'd8;

    // Beat kinds
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_POINT = 1'b1;

    // Accepted input beat as seen by every cell
    typedef struct packed {
        logic               load;
        logic               point;
        logic [SLOT_W-1:0]  slot;
        logic [DIMI_W-1:0]  dim;
        logic [IDENT_W-1:0] ident;
    } t_beat;

    // Running best candidate handed along the chain of cells
    typedef struct packed {
        logic               vld;
        logic               found;
        logic [ACC_W-1:0]   sq_dist;
        logic [SLOT_W-1:0]  slot;
        logic [IDENT_W-1:0] ident;
    } t_tok;

endpackage

// ===== hdl/nca_in_if.sv =====
interface nca_in_if;
    logic                            valid;
    logic                            ready;
    logic                            mode;
    logic [nca_pkg::SLOT_W-1:0]      slot;
    logic [nca_pkg::DIMI_W-1:0]      dim_index;
    logic signed [nca_pkg::COORD_W-1:0] coord_value;
    logic [nca_pkg::IDENT_W-1:0]     center_ident;
    logic [nca_pkg::PIDX_W-1:0]      point_index;
    logic                            last_coord;

    modport source (
        output valid, mode, slot, dim_index, coord_value, center_ident, point_index,
               last_coord,
        input  ready
    );

    modport sink (
        input  valid, mode, slot, dim_index, coord_value, center_ident, point_index,
               last_coord,
        output ready
    );
endinterface

// ===== hdl/nca_out_if.sv =====
interface nca_out_if;
    logic                          valid;
    logic                          ready;
    logic [nca_pkg::PIDX_W-1:0]    out_point;
    logic [nca_pkg::IDENT_W-1:0]   center_id;
    logic [nca_pkg::SLOT_W-1:0]    best_slot;
    logic [nca_pkg::ACC_W-1:0]     best_distance;

    modport source (
        output valid, out_point, center_id, best_slot, best_distance,
        input  ready
    );

    modport sink (
        input  valid, out_point, center_id, best_slot, best_distance,
        output ready
    );
endinterface

// ===== hdl/nearest_center_assign.sv =====
// Channel   Direction  Beat contents
// i_in      sink       mode, slot, dim_index, coord_value, center_ident, point_index, last_coord
// o_out     source     out_point, center_id, best_slot, best_distance
// i_cfg_*   write      num_candidates (4 bits)
//
// Load beats and point beats without last_coord are taken one per cycle while no search is pending.
// A point beat with last_coord holds i_in.ready low until its result is loaded:
// the difference, square and accumulate registers finish the distance in every
// cell, the search token walks the chain of NUM_SLOTS cells, one cell per cycle
// unless o_out stalls, and the result is then loaded into the output register.
// The result waits in an output register; a stalled o_out holds the token at the chain end.
// Reset is synchronous, active low; it clears the accumulators and the control state.
module nearest_center_assign #(
    parameter int NUM_SLOTS  = nca_pkg::NUM_SLOTS_DEF,
    parameter int DIM        = nca_pkg::DIM_DEF,
    parameter int COORD_BITS = nca_pkg::COORD_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    nca_in_if.sink                    i_in,
    nca_out_if.source                 o_out,
    input  logic                      i_cfg_wr_en,
    input  logic [nca_pkg::CFG_W-1:0] i_cfg_wr_data
);

    logic                              r_busy;
    logic [nca_pkg::CFG_W-1:0]         r_num_cand;
    logic                              w_in_acc;
    logic                              w_last_acc;
    nca_pkg::t_beat                    w_beat;
    logic signed [COORD_BITS-1:0]      w_coord;
    logic                              r_a_last;
    logic                              r_b_last;
    logic                              r_start;
    logic [nca_pkg::PIDX_W-1:0]        r_pidx;
    nca_pkg::t_tok                     w_tok_in;
    nca_pkg::t_tok                     w_tok [NUM_SLOTS+1];
    nca_pkg::t_tok                     w_end;
    logic                              w_out_load;
    logic                              w_adv;
    logic                              r_out_vld;
    logic [nca_pkg::PIDX_W-1:0]        r_out_point;
    logic [nca_pkg::IDENT_W-1:0]       r_out_id;
    logic [nca_pkg::SLOT_W-1:0]        r_out_slot;
    logic [nca_pkg::ACC_W-1:0]         r_out_dist;

    // Input handshake and beat decode.
    assign i_in.ready = !r_busy;
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_last_acc = w_in_acc && (i_in.mode == nca_pkg::MODE_POINT) && i_in.last_coord;

    assign w_beat.load  = w_in_acc && (i_in.mode == nca_pkg::MODE_LOAD);
    assign w_beat.point = w_in_acc && (i_in.mode == nca_pkg::MODE_POINT);
    assign w_beat.slot  = i_in.slot;
    assign w_beat.dim   = i_in.dim_index;
    assign w_beat.ident = i_in.center_ident;

    // Coordinate taken at the internal width, keeping its sign.
    assign w_coord = COORD_BITS'(i_in.coord_value);

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_cand <= nca_pkg::NUM_CAND_RST;
        end else if (i_cfg_wr_en) begin
            r_num_cand <= i_cfg_wr_data;
        end
    end

    // Last-coordinate flag follows the cell pipeline, then starts the search.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_last <= 1'b0;
            r_b_last <= 1'b0;
            r_start  <= 1'b0;
            r_busy   <= 1'b0;
        end else begin
            r_a_last <= w_last_acc;
            r_b_last <= r_a_last;
            r_start  <= r_b_last;
            if (w_last_acc) begin
                r_busy <= 1'b1;
            end else if (w_out_load) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_last_acc) begin
            r_pidx <= i_in.point_index;
        end
    end

    // Chain of slot cells; the token enters at slot zero with no candidate.
    always_comb begin
        w_tok_in     = '0;
        w_tok_in.vld = r_start;
    end

    assign w_tok[0] = w_tok_in;

    for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_cell
        nca_cell #(
            .CELL_IDX   (k),
            .DIM        (DIM),
            .COORD_BITS (COORD_BITS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_beat     (w_beat),
            .i_coord    (w_coord),
            .i_num_cand (r_num_cand),
            .i_adv      (w_adv),
            .i_tok      (w_tok[k]),
            .o_tok      (w_tok[k+1])
        );
    end

    // Output register; the chain holds while a finished token cannot leave.
    assign w_end      = w_tok[NUM_SLOTS];
    assign w_out_load = w_end.vld && (!r_out_vld || o_out.ready);
    assign w_adv      = !w_end.vld || w_out_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_load) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_point <= r_pidx;
            r_out_id    <= w_end.ident;
            r_out_slot  <= w_end.slot;
            r_out_dist  <= w_end.sq_dist;
        end
    end

    assign o_out.valid         = r_out_vld;
    assign o_out.out_point     = r_out_point;
    assign o_out.center_id     = r_out_id;
    assign o_out.best_slot     = r_out_slot;
    assign o_out.best_distance = r_out_dist;

`ifndef SYNTHESIS
    logic [NUM_SLOTS-1:0] w_tok_vld;

    always_comb begin
        for (int k = 0; k < NUM_SLOTS; k++) begin
            w_tok_vld[k] = w_tok[k+1].vld;
        end
    end

    // At most one search token is in the chain.
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_tok_vld) <= 1)
        else $error("more than one search token in the cell chain");

    // A result is only produced for a point under search.
    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |-> r_busy)
        else $error("result loaded while no point was pending");

    // No beat is taken while the search runs.
    a_search_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_start || (w_tok_vld != '0)) |-> !i_in.ready)
        else $error("input taken during the search");

    // A final coordinate, once taken, closes the input.
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_last_acc |=> !i_in.ready)
        else $error("input still open after a final coordinate");
`endif

endmodule

// ===== hdl/nca_cell.sv =====
module nca_cell #(
    parameter int CELL_IDX   = 0,
    parameter int DIM        = nca_pkg::DIM_DEF,
    parameter int COORD_BITS = nca_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  nca_pkg::t_beat               i_beat,
    input  logic signed [COORD_BITS-1:0] i_coord,
    input  logic [nca_pkg::CFG_W-1:0]    i_num_cand,
    input  logic                         i_adv,
    input  nca_pkg::t_tok                i_tok,
    output nca_pkg::t_tok                o_tok
);

    localparam int MAG_W = COORD_BITS + 1;
    localparam int SQ_W  = 2 * MAG_W;

    // Centre held by this slot
    logic signed [COORD_BITS-1:0]    r_coord [DIM];
    logic [nca_pkg::IDENT_W-1:0]     r_ident;

    logic signed [COORD_BITS-1:0]    w_csel;
    logic                            w_hit;
    logic signed [MAG_W-1:0]         w_diff;
    logic [MAG_W-1:0]                w_mag;
    logic [MAG_W-1:0]                r_mag;
    logic                            r_a_vld;
    logic [SQ_W-1:0]                 w_sq;
    logic [nca_pkg::ACC_W-1:0]       w_sq_sat;
    logic [nca_pkg::ACC_W-1:0]       r_sq;
    logic                            r_b_vld;
    logic [nca_pkg::ACC_W:0]         w_sum;
    logic [nca_pkg::ACC_W-1:0]       r_acc;
    logic                            w_in_search;
    logic                            w_take;
    nca_pkg::t_tok                   n_tok;
    nca_pkg::t_tok                   r_tok;

    // Load beats addressed to this slot write the id and, when in range, one coordinate.
    always_ff @(posedge i_clk) begin
        if (i_beat.load && (int'(i_beat.slot) == CELL_IDX)) begin
            r_ident <= i_beat.ident;
            for (int j = 0; j < DIM; j++) begin
                if (int'(i_beat.dim) == j) begin
                    r_coord[j] <= i_coord;
                end
            end
        end
    end

    // Select the stored coordinate named by the beat.
    always_comb begin
        w_csel = '0;
        w_hit  = 1'b0;
        for (int j = 0; j < DIM; j++) begin
            if (int'(i_beat.dim) == j) begin
                w_csel = r_coord[j];
                w_hit  = 1'b1;
            end
        end
    end

    // First stage: absolute difference.
    assign w_diff = MAG_W'(i_coord) - MAG_W'(w_csel);
    assign w_mag  = w_diff[MAG_W-1] ? MAG_W'(-w_diff) : MAG_W'(w_diff);

    // Second stage: square, saturated to the accumulator width.
    assign w_sq     = SQ_W'(r_mag) * SQ_W'(r_mag);
    assign w_sq_sat = (w_sq > SQ_W'(nca_pkg::ACC_MAX)) ? nca_pkg::ACC_MAX
                                                        : nca_pkg::ACC_W'(w_sq);

    // Third stage: saturating accumulate.
    assign w_sum = {1'b0, r_acc} + {1'b0, r_sq};

    always_ff @(posedge i_clk) begin
        r_mag <= w_mag;
        r_sq  <= w_sq_sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_acc   <= '0;
        end else begin
            r_a_vld <= i_beat.point && w_hit;
            r_b_vld <= r_a_vld;
            if (i_adv && i_tok.vld) begin
                r_acc <= '0;
            end else if (r_b_vld) begin
                r_acc <= w_sum[nca_pkg::ACC_W] ? nca_pkg::ACC_MAX
                                               : w_sum[nca_pkg::ACC_W-1:0];
            end
        end
    end

    // Search step: a candidate cell takes over the running best when none is found yet or when strictly nearer.
    assign w_in_search = (CELL_IDX == 0) || (CELL_IDX < int'(i_num_cand));
    assign w_take      = w_in_search && (!i_tok.found || (r_acc < i_tok.sq_dist));

    always_comb begin
        n_tok = i_tok;
        if (w_take) begin
            n_tok.found   = 1'b1;
            n_tok.sq_dist = r_acc;
            n_tok.slot    = nca_pkg::SLOT_W'(CELL_IDX);
            n_tok.ident   = r_ident;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else if (i_adv) begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule
